FILE: hdl/segint_pkg.sv
// ----------------------------------------------------------------------------
// segint_pkg
// Shared widths, the result kind codes and the queue entry of the
// segment intersection block.
// ----------------------------------------------------------------------------
package segint_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;

	// endpoint difference, single product, two-product sum
	localparam int DW  = COORD_BITS + 1;
	localparam int PW  = 2 * DW;
	localparam int SW  = PW + 1;
	// magnitude of a cross or dot product, numerators and denominators
	localparam int MW  = 2 * COORD_BITS + 1;
	// quotient bits of the scaled parameter times the direction
	localparam int QB  = COORD_BITS + FRAC_BITS;
	localparam int PRW = COORD_BITS + MW;
	localparam int NW  = PRW + FRAC_BITS;

	localparam int OUT_W  = 32;
	localparam int VW     = (QB + 2 > OUT_W) ? QB + 2 : OUT_W;
	localparam int IN_W   = ((8 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DW = 4 * OUT_W;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_POINT   = 2'd1,
		KIND_OVERLAP = 2'd2
	} kind_t;

	// channel order in prod: start x, start y, end x, end y
	typedef struct packed {
		kind_t                         kind;
		logic [MW-1:0]                 den;
		logic [3:0][PRW-1:0]           prod;
		logic signed [COORD_BITS-1:0]  ax;
		logic signed [COORD_BITS-1:0]  ay;
		logic                          neg_x;
		logic                          neg_y;
		logic                          zero_s;
		logic                          zero_e;
	} job_t;

endpackage

FILE: hdl/segint_front.sv
// ----------------------------------------------------------------------------
// segint_front
// Accepts segment pairs, forms cross and dot products, classifies the pair
// and prepares the numerator products for the back end.
// ----------------------------------------------------------------------------
module segint_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [segint_pkg::IN_W-1:0]   in_data,
	input  logic                          q_full,
	output logic                          push,
	output segint_pkg::job_t              job
);

	localparam int C  = segint_pkg::COORD_BITS;
	localparam int DW = segint_pkg::DW;
	localparam int PW = segint_pkg::PW;
	localparam int SW = segint_pkg::SW;
	localparam int MW = segint_pkg::MW;
	localparam int PRW = segint_pkg::PRW;

	function automatic logic signed [SW-1:0] cross2(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b, input logic signed [DW-1:0] c,
			input logic signed [DW-1:0] d);
		logic signed [PW-1:0] p;
		logic signed [PW-1:0] q;
		p = a * b;
		q = c * d;
		return SW'(p) - SW'(q);
	endfunction

	function automatic logic signed [SW-1:0] dot2(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b, input logic signed [DW-1:0] c,
			input logic signed [DW-1:0] d);
		logic signed [PW-1:0] p;
		logic signed [PW-1:0] q;
		p = a * b;
		q = c * d;
		return SW'(p) + SW'(q);
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [C-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1, dx_s1, dy_s1;

	logic signed [DW-1:0] e1x, e1y, e2x, e2y, wx, wy, vx, vy;

	logic signed [SW-1:0] den_s2, tn_s2, un_s2, dcr_s2, ddot_s2;
	logic signed [SW-1:0] len_s2, pc_s2, pd_s2, dot12_s2;
	logic signed [DW-1:0] e1x_s2, e1y_s2;
	logic signed [C-1:0]  ax_s2, ay_s2;

	logic signed [SW-1:0] dn, tnn, unn, pcc, pdd, sp, ep;
	logic signed [DW-1:0] magx_w, magy_w;
	segint_pkg::kind_t    kind_c;
	logic [MW-1:0]        den_c, nums_c, nume_c;

	segint_pkg::kind_t    kind_s3;
	logic [MW-1:0]        den_s3, nums_s3, nume_s3;
	logic [C-1:0]         magx_s3, magy_s3;
	logic                 negx_s3, negy_s3;
	logic signed [C-1:0]  ax_s3, ay_s3;

	segint_pkg::job_t     job_s4;

	assign en       = !(v_s4 && q_full);
	assign in_ready = en;
	assign push     = v_s4 && !q_full;
	assign job      = job_s4;

	assign e1x = DW'(bx_s1) - DW'(ax_s1);
	assign e1y = DW'(by_s1) - DW'(ay_s1);
	assign e2x = DW'(dx_s1) - DW'(cx_s1);
	assign e2y = DW'(dy_s1) - DW'(cy_s1);
	assign wx  = DW'(cx_s1) - DW'(ax_s1);
	assign wy  = DW'(cy_s1) - DW'(ay_s1);
	assign vx  = DW'(ax_s1) - DW'(dx_s1);
	assign vy  = DW'(ay_s1) - DW'(dy_s1);

	// classification on exact products
	always_comb begin
		dn     = den_s2[SW-1] ? -den_s2 : den_s2;
		tnn    = den_s2[SW-1] ? -tn_s2 : tn_s2;
		unn    = den_s2[SW-1] ? -un_s2 : un_s2;
		pcc    = (dot12_s2[SW-1]) ? pd_s2 : pc_s2;
		pdd    = (dot12_s2[SW-1]) ? pc_s2 : pd_s2;
		sp     = pcc[SW-1] ? '0 : pcc;
		ep     = (pdd < len_s2) ? pdd : len_s2;
		kind_c = segint_pkg::KIND_NONE;
		den_c  = MW'(1);
		nums_c = '0;
		nume_c = '0;
		priority if (den_s2 != '0) begin
			if (!tnn[SW-1] && tnn <= dn && !unn[SW-1] && unn <= dn) begin
				kind_c = segint_pkg::KIND_POINT;
				den_c  = MW'(dn);
				nums_c = MW'(tnn);
			end
		end else if (e1x_s2 == '0 && e1y_s2 == '0) begin
			// degenerate first segment: point on closed segment test
			if (dcr_s2 == '0 && (ddot_s2[SW-1] || ddot_s2 == '0)) begin
				kind_c = segint_pkg::KIND_OVERLAP;
			end
		end else if (un_s2 == '0) begin
			if (sp <= ep) begin
				kind_c = segint_pkg::KIND_OVERLAP;
				den_c  = MW'(len_s2);
				nums_c = MW'(sp);
				nume_c = MW'(ep);
			end
		end else begin
			kind_c = segint_pkg::KIND_NONE;
		end
		magx_w = e1x_s2[DW-1] ? -e1x_s2 : e1x_s2;
		magy_w = e1y_s2[DW-1] ? -e1y_s2 : e1y_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= in_data[0*C +: C];
			ay_s1 <= in_data[1*C +: C];
			bx_s1 <= in_data[2*C +: C];
			by_s1 <= in_data[3*C +: C];
			cx_s1 <= in_data[4*C +: C];
			cy_s1 <= in_data[5*C +: C];
			dx_s1 <= in_data[6*C +: C];
			dy_s1 <= in_data[7*C +: C];

			den_s2   <= cross2(e1x, e2y, e1y, e2x);
			tn_s2    <= cross2(wx, e2y, wy, e2x);
			un_s2    <= cross2(wx, e1y, wy, e1x);
			dcr_s2   <= cross2(-wx, vy, -wy, vx);
			ddot_s2  <= dot2(-wx, vx, -wy, vy);
			len_s2   <= dot2(e1x, e1x, e1y, e1y);
			pc_s2    <= dot2(wx, e1x, wy, e1y);
			pd_s2    <= dot2(-vx, e1x, -vy, e1y);
			dot12_s2 <= dot2(e1x, e2x, e1y, e2y);
			e1x_s2   <= e1x;
			e1y_s2   <= e1y;
			ax_s2    <= ax_s1;
			ay_s2    <= ay_s1;

			kind_s3 <= kind_c;
			den_s3  <= den_c;
			nums_s3 <= nums_c;
			nume_s3 <= nume_c;
			magx_s3 <= C'(magx_w);
			magy_s3 <= C'(magy_w);
			negx_s3 <= e1x_s2[DW-1];
			negy_s3 <= e1y_s2[DW-1];
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;

			job_s4.kind    <= kind_s3;
			job_s4.den     <= den_s3;
			job_s4.prod[0] <= PRW'(magx_s3) * PRW'(nums_s3);
			job_s4.prod[1] <= PRW'(magy_s3) * PRW'(nums_s3);
			job_s4.prod[2] <= PRW'(magx_s3) * PRW'(nume_s3);
			job_s4.prod[3] <= PRW'(magy_s3) * PRW'(nume_s3);
			job_s4.ax      <= ax_s3;
			job_s4.ay      <= ay_s3;
			job_s4.neg_x   <= negx_s3;
			job_s4.neg_y   <= negy_s3;
			job_s4.zero_s  <= (kind_s3 == segint_pkg::KIND_NONE);
			job_s4.zero_e  <= (kind_s3 != segint_pkg::KIND_OVERLAP);
		end
	end

endmodule

FILE: hdl/segint_fifo.sv
// ----------------------------------------------------------------------------
// segint_fifo
// Short queue of classified jobs between the front and the back end.
// ----------------------------------------------------------------------------
module segint_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  segint_pkg::job_t  wr_job,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output segint_pkg::job_t  rd_job
);

	localparam int QAW = segint_pkg::QAW;

	segint_pkg::job_t mem_q [segint_pkg::QDEPTH];
	logic [QAW-1:0]   wptr_q, rptr_q;
	logic [QAW:0]     cnt_q;

	assign full   = (cnt_q == (QAW+1)'(segint_pkg::QDEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

endmodule

FILE: hdl/segint_div.sv
// ----------------------------------------------------------------------------
// segint_div
// Pipelined restoring divider, one quotient bit per stage, with remainder.
// ----------------------------------------------------------------------------
module segint_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [segint_pkg::NW-1:0]   numer,
	input  logic [segint_pkg::MW-1:0]   den,
	output logic [segint_pkg::QB-1:0]   quo,
	output logic [segint_pkg::MW-1:0]   rem,
	output logic [segint_pkg::MW-1:0]   den_o
);

	localparam int QB = segint_pkg::QB;
	localparam int MW = segint_pkg::MW;
	localparam int NW = segint_pkg::NW;

	logic [MW-1:0] rem_s [QB];
	logic [QB-1:0] low_s [QB];
	logic [QB-1:0] quo_s [QB];
	logic [MW-1:0] den_s [QB];

	genvar k;
	generate
		for (k = 0; k < QB; k++) begin : g_stage
			logic [MW-1:0] r_in;
			logic [QB-1:0] l_in;
			logic [QB-1:0] q_in;
			logic [MW-1:0] d_in;
			logic [MW:0]   t;
			logic          ge;

			if (k == 0) begin : g_first
				// high part is below den since the quotient fits in QB bits
				assign r_in = numer[NW-1:QB];
				assign l_in = numer[QB-1:0];
				assign q_in = '0;
				assign d_in = den;
			end else begin : g_next
				assign r_in = rem_s[k-1];
				assign l_in = low_s[k-1];
				assign q_in = quo_s[k-1];
				assign d_in = den_s[k-1];
			end

			assign t  = {r_in, l_in[QB-1]};
			assign ge = (t >= {1'b0, d_in});

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? MW'(t - {1'b0, d_in}) : MW'(t);
					low_s[k] <= {l_in[QB-2:0], 1'b0};
					quo_s[k] <= {q_in[QB-2:0], ge};
					den_s[k] <= d_in;
				end
			end
		end
	endgenerate

	assign quo   = quo_s[QB-1];
	assign rem   = rem_s[QB-1];
	assign den_o = den_s[QB-1];

endmodule

FILE: hdl/segint_back.sv
// ----------------------------------------------------------------------------
// segint_back
// Divides the four coordinate products, rounds to nearest and forms the
// fixed-point result in the output register.
// ----------------------------------------------------------------------------
module segint_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	input  segint_pkg::job_t                job,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [segint_pkg::OUT_DW-1:0]   m_tdata,
	output logic [1:0]                      m_tuser
);

	localparam int C     = segint_pkg::COORD_BITS;
	localparam int F     = segint_pkg::FRAC_BITS;
	localparam int QB    = segint_pkg::QB;
	localparam int MW    = segint_pkg::MW;
	localparam int VW    = segint_pkg::VW;
	localparam int OUT_W = segint_pkg::OUT_W;

	typedef struct packed {
		segint_pkg::kind_t    kind;
		logic signed [C-1:0]  ax;
		logic signed [C-1:0]  ay;
		logic                 neg_x;
		logic                 neg_y;
		logic                 zero_s;
		logic                 zero_e;
	} side_t;

	logic             en;
	logic             v_s [QB];
	side_t            side_s [QB];
	side_t            side_in;
	logic             m_tvalid_q;
	logic [segint_pkg::OUT_DW-1:0] m_tdata_q;
	logic [1:0]       m_tuser_q;

	logic [QB-1:0]    quo [4];
	logic [MW-1:0]    rem [4];
	logic [MW-1:0]    dsor [4];
	logic [OUT_W-1:0] res [4];

	assign en       = !m_tvalid_q || m_tready;
	assign pop      = en && !q_empty;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign side_in.kind   = job.kind;
	assign side_in.ax     = job.ax;
	assign side_in.ay     = job.ay;
	assign side_in.neg_x  = job.neg_x;
	assign side_in.neg_y  = job.neg_y;
	assign side_in.zero_s = job.zero_s;
	assign side_in.zero_e = job.zero_e;

	genvar ch;
	generate
		for (ch = 0; ch < 4; ch++) begin : g_ch
			logic [MW:0]          two_r;
			logic                 neg;
			logic                 zero;
			logic                 inc;
			logic [QB:0]          magr;
			logic signed [VW-1:0] base;
			logic signed [VW-1:0] val;

			segint_div u_div (
				.clk   (clk),
				.en    (en),
				.numer ({job.prod[ch], {F{1'b0}}}),
				.den   (job.den),
				.quo   (quo[ch]),
				.rem   (rem[ch]),
				.den_o (dsor[ch])
			);

			assign neg   = (ch % 2 == 0) ? side_s[QB-1].neg_x : side_s[QB-1].neg_y;
			assign zero  = (ch < 2) ? side_s[QB-1].zero_s : side_s[QB-1].zero_e;
			assign two_r = {rem[ch], 1'b0};
			// halves round toward plus infinity
			assign inc   = neg ? (two_r > {1'b0, dsor[ch]}) : (two_r >= {1'b0, dsor[ch]});
			assign magr  = (QB+1)'(quo[ch]) + (QB+1)'(inc);
			assign base  = ((ch % 2 == 0) ? VW'(side_s[QB-1].ax) : VW'(side_s[QB-1].ay)) <<< F;
			assign val   = neg ? base - VW'(magr) : base + VW'(magr);
			assign res[ch] = zero ? '0 : val[OUT_W-1:0];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QB; i++) begin
				v_s[i] <= 1'b0;
			end
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= pop;
			for (int i = 1; i < QB; i++) begin
				v_s[i] <= v_s[i-1];
			end
			m_tvalid_q <= v_s[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int i = 1; i < QB; i++) begin
				side_s[i] <= side_s[i-1];
			end
			m_tdata_q <= {res[3], res[2], res[1], res[0]};
			m_tuser_q <= side_s[QB-1].kind;
		end
	end

endmodule

FILE: hdl/segment_intersection_with_overlap_top.sv
// throughput: one segment pair per cycle unless the output stalls, set by the 32-stage pipelined dividers
// a 4-entry queue lets the classifier front end and the divider back end stall apart
// reset: arst_n clears all valid flags and queue pointers, no clearing pass
// ----------------------------------------------------------------------------
// segment_intersection_with_overlap_top
// Classifies two 2D segments as disjoint, crossing or collinear overlap and
// returns the points in fixed point, rounded to nearest.
// ----------------------------------------------------------------------------
module segment_intersection_with_overlap_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// ax, ay, bx, by, cx, cy, dx, dy from the lowest bit up
	input  logic [segint_pkg::IN_W-1:0]     s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// start_x, start_y, end_x, end_y from the lowest bit up
	output logic [segint_pkg::OUT_DW-1:0]   m_tdata,
	// kind
	output logic [1:0]                      m_tuser
);

	logic             push, full, pop, empty;
	segint_pkg::job_t wr_job, rd_job;

	segint_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.q_full   (full),
		.push     (push),
		.job      (wr_job)
	);

	segint_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rd_job (rd_job)
	);

	segint_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (empty),
		.job      (rd_job),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: bench/seg_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seg_scoreboard
// Predicts the intersection class and fixed-point points of each accepted
// segment pair and compares the block's results against them in order.
// ----------------------------------------------------------------------------
class seg_scoreboard;
	localparam int FB = segint_pkg::FRAC_BITS;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] sx, sy, ex, ey;
	} isect_t;

	isect_t pending_q[$];
	int     mismatches;
	int     compared;
	int     kind_seen [3];

	function new();
		mismatches = 0;
		compared = 0;
		foreach (kind_seen[i]) kind_seen[i] = 0;
	endfunction

	// a + dv*num/den in fixed point, nearest, half toward plus infinity
	static function longint fixed_point(longint a, longint dv, longint num, longint den);
		logic signed [127:0] scaled;
		logic signed [127:0] q;
		logic signed [127:0] r;
		scaled = 128'(dv) * 128'(num) * (128'sd1 <<< FB);
		q = scaled / 128'(den);
		r = scaled % 128'(den);
		// truncation went toward zero, move to floor
		if (r < 0) begin
			q = q - 1;
			r = r + 128'(den);
		end
		if (2 * r >= 128'(den))
			q = q + 1;
		return (a <<< FB) + longint'(q);
	endfunction

	function void note_pair(logic [127:0] d);
		longint ax, ay, bx, by, cx, cy, dx, dy;
		longint e1x, e1y, e2x, e2y, wx, wy, den, tn, un;
		longint ux, uy, vx, vy, len, pc, pd, tmp, s, e;
		longint sx, sy, ex, ey;
		isect_t r;
		ax = longint'($signed(d[15:0]));    ay = longint'($signed(d[31:16]));
		bx = longint'($signed(d[47:32]));   by = longint'($signed(d[63:48]));
		cx = longint'($signed(d[79:64]));   cy = longint'($signed(d[95:80]));
		dx = longint'($signed(d[111:96]));  dy = longint'($signed(d[127:112]));
		e1x = bx - ax; e1y = by - ay; e2x = dx - cx; e2y = dy - cy;
		wx = cx - ax; wy = cy - ay;
		den = e1x * e2y - e1y * e2x;
		sx = 0; sy = 0; ex = 0; ey = 0;
		r.kind = segint_pkg::KIND_NONE;
		if (den != 0) begin
			tn = wx * e2y - wy * e2x;
			un = wx * e1y - wy * e1x;
			if (den < 0) begin
				den = -den; tn = -tn; un = -un;
			end
			if (tn >= 0 && tn <= den && un >= 0 && un <= den) begin
				r.kind = segint_pkg::KIND_POINT;
				sx = fixed_point(ax, e1x, tn, den);
				sy = fixed_point(ay, e1y, tn, den);
			end
		end else if (e1x == 0 && e1y == 0) begin
			ux = ax - cx; uy = ay - cy; vx = ax - dx; vy = ay - dy;
			if (ux * vy - uy * vx == 0 && ux * vx + uy * vy <= 0) begin
				r.kind = segint_pkg::KIND_OVERLAP;
				sx = ax <<< FB; sy = ay <<< FB; ex = sx; ey = sy;
			end
		end else if (wx * e1y - wy * e1x == 0) begin
			len = e1x * e1x + e1y * e1y;
			pc = wx * e1x + wy * e1y;
			pd = (dx - ax) * e1x + (dy - ay) * e1y;
			if (e1x * e2x + e1y * e2y < 0) begin
				tmp = pc; pc = pd; pd = tmp;
			end
			s = pc > 0 ? pc : 0;
			e = pd < len ? pd : len;
			if (s <= e) begin
				r.kind = segint_pkg::KIND_OVERLAP;
				sx = fixed_point(ax, e1x, s, len);
				sy = fixed_point(ay, e1y, s, len);
				ex = fixed_point(ax, e1x, e, len);
				ey = fixed_point(ay, e1y, e, len);
			end
		end
		r.sx = sx[31:0]; r.sy = sy[31:0]; r.ex = ex[31:0]; r.ey = ey[31:0];
		pending_q.push_back(r);
	endfunction

	function void check_result(logic [1:0] kind, logic [127:0] d);
		isect_t x;
		if (pending_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result kind=%0d data=%h", kind, d);
			return;
		end
		x = pending_q.pop_front();
		compared++;
		if (x.kind < 3) kind_seen[x.kind]++;
		if (kind !== x.kind || d[31:0] !== x.sx || d[63:32] !== x.sy ||
				d[95:64] !== x.ex || d[127:96] !== x.ey) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp kind=%0d %h %h %h %h got kind=%0d %h %h %h %h",
					x.kind, x.sx, x.sy, x.ex, x.ey,
					kind, d[31:0], d[63:32], d[95:64], d[127:96]);
		end
	endfunction
endclass

FILE: bench/tb_segment_intersection_with_overlap_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_with_overlap_top
// Drives directed and random segment pairs through the intersection block
// under several idle and stall mixes and checks every result in order.
// ----------------------------------------------------------------------------
module tb_segment_intersection_with_overlap_top;
	localparam int LATENCY = 38;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic [1:0]   m_tuser;

	int           idle_pct;
	int           stall_pct;
	seg_scoreboard board;

	segment_intersection_with_overlap_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// receiver side: random stalls and result checks
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				board.check_result(m_tuser, m_tdata);
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	function automatic logic [15:0] rand_coord(int span);
		int mode;
		mode = $urandom_range(9);
		if (mode == 0) return 16'h8000;
		if (mode == 1) return 16'h7fff;
		if (mode < 5) return 16'($urandom);
		return 16'($signed($urandom_range(2 * span)) - span);
	endfunction

	task automatic send_pair(logic [15:0] ax, ay, bx, by, cx, cy, dx, dy);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dy, dx, cy, cx, by, bx, ay, ax};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_pair({dy, dx, cy, cx, by, bx, ay, ax});
	endtask

	// random pair; collinear, degenerate and crossing shapes are built on purpose
	task automatic send_random(int span);
		logic [15:0] ax, ay, bx, by, cx, cy, dx, dy;
		int kx, ky, t0, t1, t2, t3, shape;
		int mx, my, ox, oy;
		ax = rand_coord(span); ay = rand_coord(span);
		bx = rand_coord(span); by = rand_coord(span);
		cx = rand_coord(span); cy = rand_coord(span);
		dx = rand_coord(span); dy = rand_coord(span);
		shape = $urandom_range(3);
		if (shape == 1) begin
			kx = $signed($urandom_range(14)) - 7; ky = $signed($urandom_range(14)) - 7;
			t0 = $signed($urandom_range(20)) - 10; t1 = $signed($urandom_range(20)) - 10;
			t2 = $signed($urandom_range(20)) - 10; t3 = $signed($urandom_range(20)) - 10;
			ax = 16'($signed($urandom_range(2000)) - 1000);
			ay = 16'($signed($urandom_range(2000)) - 1000);
			bx = ax + 16'(t0 * kx); by = ay + 16'(t0 * ky);
			cx = ax + 16'(t1 * kx); cy = ay + 16'(t1 * ky);
			dx = ax + 16'(t2 * kx); dy = ay + 16'(t2 * ky);
			if (t3 == 0) begin
				bx = ax; by = ay;
			end
		end else if (shape == 2) begin
			// crossing near the middle: cd spans ab
			mx = (int'($signed(ax)) + int'($signed(bx))) / 2;
			my = (int'($signed(ay)) + int'($signed(by))) / 2;
			ox = $signed($urandom_range(200)) - 100;
			oy = $signed($urandom_range(200)) - 100;
			cx = 16'(mx + ox); cy = 16'(my + oy);
			dx = 16'(mx - ox); dy = 16'(my - oy);
		end
		send_pair(ax, ay, bx, by, cx, cy, dx, dy);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (board.pending_q.size() != 0) @(posedge clk);
		while (guard < LATENCY + 10) begin
			@(posedge clk);
			guard++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		idle_pct = 0;
		stall_pct = 0;
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain crossings, crossing at a corner, extremes
		send_pair(0, 0, 10, 10, 0, 10, 10, 0);
		send_pair(0, 0, 3, 0, 1, -1, 2, 2);
		send_pair(0, 0, 10, 0, 10, 0, 10, 5);
		send_pair(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		send_pair(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
		send_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		// no crossing within segment range
		send_pair(0, 0, 1, 1, 5, 0, 6, -3);
		// parallel, not collinear
		send_pair(0, 0, 4, 0, 0, 1, 4, 1);
		// collinear overlap, same and opposite direction, touching, disjoint, containing
		send_pair(0, 0, 10, 0, 5, 0, 20, 0);
		send_pair(0, 0, 10, 0, 20, 0, 5, 0);
		send_pair(0, 0, 10, 10, 10, 10, 20, 20);
		send_pair(0, 0, 3, 3, 5, 5, 9, 9);
		send_pair(0, 0, 7, 3, -7, -3, 14, 6);
		// degenerate ab on cd, off cd, and at an end of cd
		send_pair(3, 3, 3, 3, 0, 0, 6, 6);
		send_pair(3, 4, 3, 4, 0, 0, 6, 6);
		send_pair(6, 6, 6, 6, 0, 0, 6, 6);
		// both degenerate
		send_pair(2, 2, 2, 2, 2, 2, 2, 2);
		// degenerate cd, crossing at a, then rounding of thirds in both directions
		send_pair(0, 0, 1, 0, 0, 0, 0, 0);
		send_pair(0, 0, -1, 0, 1, -1, -2, 2);
		send_pair(0, 0, 3, 1, 1, 0, 1, 5);
		send_pair(0, 0, -3, -1, -1, 0, -1, -5);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 83; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 83; end
				3: begin idle_pct = 28; stall_pct = 28; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			for (int i = 0; i < 140; i++)
				send_random(ph == 4 ? 32767 : 60);
		end
		drain();

		$display("checked %0d results: %0d none, %0d crossing, %0d overlap",
			board.compared, board.kind_seen[0], board.kind_seen[1], board.kind_seen[2]);
		$display("directed corners and extremes, then random pairs under idle and stall mixes");
		if (board.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", board.mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
